[rtl/pbc_adj_pkg.sv]
package pbc_adj_pkg;

  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 8;
  localparam int LEVEL_W   = 9;
  localparam int GAIN_W    = 22;

  localparam logic [PIX_W-1:0] EXT_LOW  = 8'd50;
  localparam logic [PIX_W-1:0] EXT_HIGH = 8'd205;
  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 3'd0,
    CFG_CONTRAST   = 3'd1,
    CFG_TONE_EN    = 3'd2,
    CFG_RED_OFS    = 3'd3,
    CFG_GREEN_OFS  = 3'd4,
    CFG_BLUE_OFS   = 3'd5,
    CFG_BALANCE_EN = 3'd6
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [LEVEL_W-1:0] level_t;

  // tonal extremes get half the brightness or offset
  function automatic logic is_extreme(input pix_t x);
    return (x < EXT_LOW) || (x > EXT_HIGH);
  endfunction

  // -256 maps to -255
  function automatic level_t clip_level(input level_t v);
    return (v == -9'sd256) ? -9'sd255 : v;
  endfunction

endpackage

[rtl/pixel_brightness_contrast_rgb_adjust_top.sv]
// Brightness / contrast and color balance adjust for 8-bit BGR pixels.
// Input channel: in_valid_i / in_stall_o with in_blue_i, in_green_i, in_red_i.
// Output channel: out_valid_o / out_stall_i with out_blue_o, out_green_o,
// out_red_o. An item moves at a rising edge where valid is high and stall low.
// Each item is captured in an input register, goes through one multiply per
// channel (12 x 23 bits, gain times offset-shifted pixel), a clamp and the
// balance add, and lands in the output register that drives out_valid_o.
// One item per cycle is taken as long as the receiver does not
// stall; both registers form a two-deep pipeline, so in_stall_o rises only
// when both hold items and out_stall_i is high.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 brightness,
// 1 contrast gain, 2 tone enable, 3..5 red/green/blue offset, 6 balance
// enable); unused indexes are ignored. Write only while the pipeline is empty.
// Reset empties the pipeline, sets the gain to 1.0 and clears the other config registers.
module pixel_brightness_contrast_rgb_adjust_top import pbc_adj_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     in_blue_i,
  input  logic [PIX_W-1:0]     in_green_i,
  input  logic [PIX_W-1:0]     in_red_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     out_blue_o,
  output logic [PIX_W-1:0]     out_green_o,
  output logic [PIX_W-1:0]     out_red_o
);

  localparam int GAIN_REG_W = (GAIN_FRAC_BITS + 1 > GAIN_W) ? GAIN_FRAC_BITS + 1 : GAIN_W;
  localparam int PROD_W     = GAIN_REG_W + 13;
  localparam int BASE_W     = GAIN_FRAC_BITS + 11;
  localparam int NUM_W      = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 2;
  localparam int QLSB       = GAIN_FRAC_BITS + 2;

  typedef logic [GAIN_REG_W-1:0] gain_t;

  level_t bright_q;
  gain_t  gain_q;
  logic   tone_en_q;
  level_t ofs_q [3];
  logic   bal_en_q;

  logic   s1_valid_q, s2_valid_q;
  pix_t   s1_pix_q [3];
  pix_t   s2_pix_q [3];
  pix_t   s2_pix_d [3];
  pix_t   in_pix [3];
  logic   s1_load, s2_load;

  // brightness / contrast on one channel
  function automatic pix_t tone_ch(input pix_t x, input level_t bl, input gain_t k);
    level_t                    b;
    logic signed [9:0]         t;
    logic signed [11:0]        d;
    logic signed [11:0]        base12;
    logic signed [PROD_W-1:0]  prod;
    logic signed [NUM_W-1:0]   num;
    logic signed [NUM_W-1:0]   base_w;
    pix_t                      r;
    b      = clip_level(bl);
    t      = is_extreme(x) ? 10'(b) : {b, 1'b0};
    d      = $signed({2'b00, x, 2'b00}) - 12'sd510 + 12'(t);
    base12 = 12'sd510 + 12'(t);
    prod   = PROD_W'(d) * PROD_W'($signed({1'b0, k}));
    base_w = $signed(NUM_W'(base12[10:0])) <<< GAIN_FRAC_BITS;
    num    = NUM_W'(prod) + base_w;
    if (num[NUM_W-1] || (num == '0)) begin
      r = '0;
    end else if (|num[NUM_W-1:QLSB+PIX_W]) begin
      r = PIX_MAX;
    end else begin
      r = num[QLSB+PIX_W-1:QLSB];
    end
    return r;
  endfunction

  // offset add on one channel
  function automatic pix_t balance_ch(input pix_t x, input level_t off);
    logic signed [9:0] o;
    logic signed [9:0] y;
    pix_t              r;
    o = 10'(clip_level(off));
    if (is_extreme(x)) begin
      o = (o + $signed({9'b0, o[9]})) >>> 1;
    end
    y = $signed({2'b00, x}) + o;
    if (y[9]) begin
      r = '0;
    end else if (y[8]) begin
      r = PIX_MAX;
    end else begin
      r = y[7:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q  <= '0;
      gain_q    <= gain_t'(1) << GAIN_FRAC_BITS;
      tone_en_q <= 1'b0;
      ofs_q[0]  <= '0;
      ofs_q[1]  <= '0;
      ofs_q[2]  <= '0;
      bal_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHTNESS: bright_q  <= cfg_data_i[LEVEL_W-1:0];
        CFG_CONTRAST:   gain_q    <= GAIN_REG_W'(cfg_data_i[GAIN_W-1:0]);
        CFG_TONE_EN:    tone_en_q <= cfg_data_i[0];
        CFG_RED_OFS:    ofs_q[2]  <= cfg_data_i[LEVEL_W-1:0];
        CFG_GREEN_OFS:  ofs_q[1]  <= cfg_data_i[LEVEL_W-1:0];
        CFG_BLUE_OFS:   ofs_q[0]  <= cfg_data_i[LEVEL_W-1:0];
        CFG_BALANCE_EN: bal_en_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline flow
  assign s2_load    = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  assign in_pix[0] = in_blue_i;
  assign in_pix[1] = in_green_i;
  assign in_pix[2] = in_red_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_pix_d[i] = s1_pix_q[i];
      if (tone_en_q) begin
        s2_pix_d[i] = tone_ch(s2_pix_d[i], bright_q, gain_q);
      end
      if (bal_en_q) begin
        s2_pix_d[i] = balance_ch(s2_pix_d[i], ofs_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s1_load || s2_load) begin
        s1_valid_q <= s1_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pix_q <= in_pix;
    end
    if (s2_load && s1_valid_q) begin
      s2_pix_q <= s2_pix_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_blue_o  = s2_pix_q[0];
  assign out_green_o = s2_pix_q[1];
  assign out_red_o   = s2_pix_q[2];

endmodule

[rtl/pbc_adj_checker.sv]
module pbc_adj_checker import pbc_adj_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] out_blue_o,
  input logic [PIX_W-1:0] out_green_o,
  input logic [PIX_W-1:0] out_red_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_blue_o)
      && $stable(out_green_o) && $stable(out_red_o))
    else $error("stalled result item changed");

  // no back pressure unless the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // back pressure only with a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // accepted item reaches the output when the receiver does not stall behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result item missing after accept");

endmodule

bind pixel_brightness_contrast_rgb_adjust_top pbc_adj_checker u_pbc_adj_checker (.*);

[tb/sv/pixel_brightness_contrast_rgb_adjust_top_test.sv]
module pixel_brightness_contrast_rgb_adjust_top_test;
  import pbc_adj_pkg::*;

  localparam int GAIN_FRAC_BITS = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int GAIN_ONE = 1 << GAIN_FRAC_BITS;
  localparam int GAIN_MAX = (1 << GAIN_W) - 1;
  localparam int GAIN_TAN89 = 3754574;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    pix_t blue;
    pix_t green;
    pix_t red;
  } px_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PIX_W-1:0] in_blue_i = '0;
  logic [PIX_W-1:0] in_green_i = '0;
  logic [PIX_W-1:0] in_red_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PIX_W-1:0] out_blue_o;
  logic [PIX_W-1:0] out_green_o;
  logic [PIX_W-1:0] out_red_o;

  pixel_brightness_contrast_rgb_adjust_top #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_blue_i  (in_blue_i),
    .in_green_i (in_green_i),
    .in_red_i   (in_red_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_blue_o (out_blue_o),
    .out_green_o(out_green_o),
    .out_red_o  (out_red_o)
  );

  // shadow copy of the adjust registers
  level_t brightness = '0;
  logic [GAIN_W-1:0] gain = GAIN_W'(GAIN_ONE);
  logic tone_on = 1'b0;
  level_t channel_ofs [3] = '{default: '0};
  logic balance_on = 1'b0;

  px_t raw_pixels [$];
  px_t adjusted_pixels [$];
  px_t next_pixel;
  bit pix_held = 1'b0;
  int unsigned src_gap = 0;
  int unsigned stall_left = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int errors = 0;

  px_t probe_pixels [8] = '{
    '{8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd255, 8'd128},
    '{8'd49,  8'd50,  8'd51},
    '{8'd204, 8'd205, 8'd206},
    '{8'h55,  8'hAA,  8'h0F},
    '{8'hAA,  8'h55,  8'hF0},
    '{8'd206, 8'd49,  8'd127}
  };

  function automatic int clip_lvl(level_t v);
    return (int'(v) < -255) ? -255 : int'(v);
  endfunction

  function automatic bit tonal_extreme(int x);
    return (x < int'(EXT_LOW)) || (x > int'(EXT_HIGH));
  endfunction

  function automatic pix_t tone_map(pix_t x);
    int b;
    int t;
    longint d;
    longint one_q;
    longint num;
    longint q;
    b = clip_lvl(brightness);
    t = tonal_extreme(int'(x)) ? b : 2 * b;
    d = 4 * int'(x) - 510 + t;
    one_q = longint'(1) << GAIN_FRAC_BITS;
    num = d * longint'(gain) + longint'(510 + t) * one_q;
    if (num <= 0) begin
      return '0;
    end
    q = num / (4 * one_q);
    return (q > 255) ? PIX_MAX : pix_t'(q);
  endfunction

  function automatic pix_t balance_shift(pix_t x, level_t ofs);
    int o;
    int y;
    o = clip_lvl(ofs);
    if (tonal_extreme(int'(x))) begin
      o = o / 2;
    end
    y = int'(x) + o;
    if (y < 0) begin
      return '0;
    end
    return (y > 255) ? PIX_MAX : pix_t'(y);
  endfunction

  function automatic px_t adjust_pixel(px_t p);
    pix_t ch [3];
    px_t r;
    ch[0] = p.blue;
    ch[1] = p.green;
    ch[2] = p.red;
    for (int i = 0; i < 3; i++) begin
      if (tone_on) begin
        ch[i] = tone_map(ch[i]);
      end
      if (balance_on) begin
        ch[i] = balance_shift(ch[i], channel_ofs[i]);
      end
    end
    r.blue = ch[0];
    r.green = ch[1];
    r.red = ch[2];
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 20;
      default: return 60;
    endcase
  endfunction

  function automatic pix_t rand_chan();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(5))
        0: return 8'd0;
        1: return 8'd49;
        2: return 8'd50;
        3: return 8'd205;
        4: return 8'd206;
        default: return 8'd255;
      endcase
    end
    return pix_t'($urandom);
  endfunction

  function automatic int random_level();
    case ($urandom_range(4))
      0: return -256;
      1: return 255;
      2: return -255;
      3: return 0;
      default: return int'($urandom_range(511)) - 256;
    endcase
  endfunction

  function automatic int random_gain();
    case ($urandom_range(5))
      0: return 0;
      1: return GAIN_MAX;
      2: return GAIN_ONE;
      3: return $urandom_range(GAIN_ONE - 1);
      4: return $urandom_range(GAIN_TAN89, GAIN_ONE);
      default: return $urandom_range(GAIN_MAX);
    endcase
  endfunction

  // upper data bits beyond the register width carry random junk
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value, input int w);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] data;
    mask = (CFG_W'(1) << w) - 1'b1;
    data = (CFG_W'($urandom) & ~mask) | (CFG_W'(value) & mask);
    case (idx)
      CFG_BRIGHTNESS: brightness = level_t'(data[LEVEL_W-1:0]);
      CFG_CONTRAST:   gain = data[GAIN_W-1:0];
      CFG_TONE_EN:    tone_on = data[0];
      CFG_RED_OFS:    channel_ofs[2] = level_t'(data[LEVEL_W-1:0]);
      CFG_GREEN_OFS:  channel_ofs[1] = level_t'(data[LEVEL_W-1:0]);
      CFG_BLUE_OFS:   channel_ofs[0] = level_t'(data[LEVEL_W-1:0]);
      CFG_BALANCE_EN: balance_on = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int br, input int gn, input bit ton, input int r,
                            input int g, input int b, input bit bal);
    cfg_write(CFG_BRIGHTNESS, br, LEVEL_W);
    cfg_write(CFG_CONTRAST, gn, GAIN_W);
    cfg_write(CFG_TONE_EN, ton, 1);
    cfg_write(CFG_RED_OFS, r, LEVEL_W);
    cfg_write(CFG_GREEN_OFS, g, LEVEL_W);
    cfg_write(CFG_BLUE_OFS, b, LEVEL_W);
    cfg_write(CFG_BALANCE_EN, bal, 1);
  endtask

  task automatic drain();
    while (raw_pixels.size() != 0 || pix_held || adjusted_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_probes();
    foreach (probe_pixels[i]) begin
      raw_pixels.push_back(probe_pixels[i]);
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // pixel driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!pix_held) begin
      if (src_gap != 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (raw_pixels.size() != 0) begin
        next_pixel = raw_pixels.pop_front();
        in_blue_i <= next_pixel.blue;
        in_green_i <= next_pixel.green;
        in_red_i <= next_pixel.red;
        in_valid_i <= 1'b1;
        pix_held = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(snk_idle_pct);
    end
  end

  // accepted item goes through the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      adjusted_pixels.push_back(adjust_pixel(px_t'{in_blue_i, in_green_i, in_red_i}));
      pix_held = 1'b0;
      src_gap = pick_gap(src_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (adjusted_pixels.size() == 0) begin
        $error("unexpected item: blue %0d green %0d red %0d",
               out_blue_o, out_green_o, out_red_o);
        errors++;
      end else begin
        want = adjusted_pixels.pop_front();
        if (out_blue_o !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_blue_o);
          errors++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_green_o);
          errors++;
        end
        if (out_red_o !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_red_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: plain pass-through
    push_probes();
    drain();

    // tone stage on with reset brightness and gain of one
    cfg_write(CFG_TONE_EN, 1, 1);
    src_idle_pct = 30;
    snk_idle_pct = 30;
    push_probes();
    drain();

    // -256 levels and zero gain
    set_config(-256, 0, 1'b1, -256, 255, 1, 1'b1);
    cfg_write(CFG_UNUSED, $urandom, CFG_W);
    push_probes();
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(255, GAIN_MAX, 1'b1, 255, 255, 255, 1'b1);
        1: set_config(-255, GAIN_TAN89, 1'b1, -255, -255, -255, 1'b1);
        default: begin
          set_config(random_level(), random_gain(), $urandom_range(3) != 0,
                     random_level(), random_level(), random_level(),
                     $urandom_range(3) != 0);
          if ($urandom_range(3) == 0) begin
            cfg_write(CFG_UNUSED, $urandom, CFG_W);
          end
        end
      endcase
      src_idle_pct = pick_pct();
      snk_idle_pct = pick_pct();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        raw_pixels.push_back(px_t'{rand_chan(), rand_chan(), rand_chan()});
      end
      drain();
    end

    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pbc_adj_pkg.sv
rtl/pixel_brightness_contrast_rgb_adjust_top.sv
rtl/pbc_adj_checker.sv
tb/sv/pixel_brightness_contrast_rgb_adjust_top_test.sv
